@@ rtl/core/fsv_pkg.sv @@
// ----------------------------------------------------------------------------
// fsv_pkg
// Shared types and constants of the flocking steering vector block.
// ----------------------------------------------------------------------------
package fsv_pkg;

  // default neighbour limit per step
  localparam int unsigned MAX_NEIGHBOURS_DEF = 8;

  // depth of the record queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // register reset values
  localparam logic [14:0] COH_THR_RST = 15'd410;
  localparam logic [14:0] DISP_THR_RST = 15'd492;
  localparam logic [15:0] COH_W_RST = 16'd32768;
  localparam logic [15:0] DISP_W_RST = 16'd62259;
  localparam logic [15:0] ALI_W_RST = 16'd6554;

  // register index (byte address / 4)
  typedef enum logic [2:0] {
    REG_COH_THR  = 3'd0,
    REG_DISP_THR = 3'd1,
    REG_COH_W    = 3'd2,
    REG_DISP_W   = 3'd3,
    REG_ALI_W    = 3'd4
  } reg_idx_e;

  // configuration seen by the back end
  typedef struct packed {
    logic [14:0] coh_thr;
    logic [14:0] disp_thr;
    logic [15:0] coh_w;
    logic [15:0] disp_w;
    logic [15:0] ali_w;
  } cfg_t;

  // classified neighbour record
  typedef struct packed {
    logic               use_mate;  // counted flockmate
    logic               last;      // closes the step
    logic signed [15:0] rel_x;
    logic signed [15:0] rel_z;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_z;
  } rec_t;

endpackage

@@ rtl/core/flocking_steer_vector.sv @@
// ----------------------------------------------------------------------------
// flocking_steer_vector
// Boids-style steering vector (cohesion, dispersion, alignment) from a run of
// neighbour records, with an APB register port.
// ----------------------------------------------------------------------------
// Each neighbour record is one input beat; the beat with tlast closes the
// step and yields one result beat. A flockmate record occupies the back end
// for its issue, two squaring steps and the threshold compare on the
// single shared multiplier; a closing record that is not a mate takes only
// its issue, and records that are neither a mate nor a step end are dropped
// at the input. A step without mates then goes straight to the output state.
// Otherwise the close adds four serial divides of the SUM_W-bit sums, SUM_W =
// 16 + clog2(MAX_NEIGHBOURS), then the multiply-accumulate states M2X, M2Z,
// C2, SX0-SX2 and SZ0-SZ2 and the output state, which registers the result
// beat. A two-entry record queue keeps the input taking beats, until it is
// full, while the back end works or a result waits.
// ----------------------------------------------------------------------------
module flocking_steer_vector import fsv_pkg::*; #(
  parameter int unsigned MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // neighbour records
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // rel_x, rel_z, vel_x, vel_z
  input  logic        s_axis_tlast,   // last
  input  logic        s_axis_tuser,   // is_mate
  // steering results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // steer_x, steer_z
  output logic [3:0]  m_axis_tuser,   // mate_count
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_q;
  logic cfg_wr;
  logic push, full, pop, q_valid;
  rec_t front_rec, q_rec;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coh_thr  <= COH_THR_RST;
      cfg_q.disp_thr <= DISP_THR_RST;
      cfg_q.coh_w    <= COH_W_RST;
      cfg_q.disp_w   <= DISP_W_RST;
      cfg_q.ali_w    <= ALI_W_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_COH_THR:  cfg_q.coh_thr  <= pwdata[14:0];
        REG_DISP_THR: cfg_q.disp_thr <= pwdata[14:0];
        REG_COH_W:    cfg_q.coh_w    <= pwdata[15:0];
        REG_DISP_W:   cfg_q.disp_w   <= pwdata[15:0];
        REG_ALI_W:    cfg_q.ali_w    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[4:2])
      REG_COH_THR:  prdata = 32'(cfg_q.coh_thr);
      REG_DISP_THR: prdata = 32'(cfg_q.disp_thr);
      REG_COH_W:    prdata = 32'(cfg_q.coh_w);
      REG_DISP_W:   prdata = 32'(cfg_q.disp_w);
      REG_ALI_W:    prdata = 32'(cfg_q.ali_w);
      default:      prdata = '0;
    endcase
  end

  fsv_front #(
    .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .rec_o         (front_rec)
  );

  fsv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (front_rec),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rec_o   (q_rec)
  );

  fsv_back #(
    .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_rec_i   (q_rec),
    .q_pop_o   (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser)
  );

endmodule

@@ rtl/core/fsv_front.sv @@
// ----------------------------------------------------------------------------
// fsv_front
// Input side: takes neighbour beats, marks counted flockmates, drops records
// that carry neither a mate nor the end of a step.
// ----------------------------------------------------------------------------
module fsv_front import fsv_pkg::*; #(
  parameter int unsigned MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,
  input  logic        full_i,
  output logic        push_o,
  output rec_t        rec_o
);

  localparam int unsigned CNT_W = $clog2(MAX_NEIGHBOURS + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             beat;

  assign s_axis_tready = ~full_i;
  assign beat          = s_axis_tvalid & s_axis_tready;

  // classify the record
  always_comb begin
    rec_o.use_mate = s_axis_tuser & (cnt_q < CNT_W'(MAX_NEIGHBOURS));
    rec_o.last     = s_axis_tlast;
    rec_o.rel_x    = s_axis_tdata[15:0];
    rec_o.rel_z    = s_axis_tdata[31:16];
    rec_o.vel_x    = s_axis_tdata[47:32];
    rec_o.vel_z    = s_axis_tdata[63:48];
  end

  assign push_o = beat & (rec_o.use_mate | rec_o.last);

  // mates counted in the current step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (beat) begin
      if (s_axis_tlast) begin
        cnt_q <= '0;
      end else if (rec_o.use_mate) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/fsv_queue.sv @@
// ----------------------------------------------------------------------------
// fsv_queue
// Short record queue between front and back.
// ----------------------------------------------------------------------------
module fsv_queue import fsv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  rec_t rec_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output rec_t rec_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  rec_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= rec_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

@@ rtl/core/fsv_div.sv @@
// ----------------------------------------------------------------------------
// fsv_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsv_div #(
  parameter int unsigned DVD_W = 19,
  parameter int unsigned DVS_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W);

  logic [DVS_W:0]    rem_q, shifted, rem_n;
  logic [DVD_W-1:0]  quo_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [STEP_W-1:0] step_q;
  logic              busy_q, done_q, ge;

  // one trial subtraction
  always_comb begin
    shifted = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
    ge      = (shifted >= {1'b0, dvs_q});
    rem_n   = ge ? (shifted - {1'b0, dvs_q}) : shifted;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_n;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

endmodule

@@ rtl/core/fsv_back.sv @@
// ----------------------------------------------------------------------------
// fsv_back
// Execution side: accumulates flockmate sums, then on the closing record of
// a step with mates divides, tests cohesion and forms the weighted steering
// vector with one shared multiplier.
// ----------------------------------------------------------------------------
module fsv_back import fsv_pkg::*; #(
  parameter int unsigned MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  input  rec_t        q_rec_i,
  output logic        q_pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [31:0] m_data_o,
  output logic [3:0]  m_user_o
);

  localparam int unsigned CNT_W  = $clog2(MAX_NEIGHBOURS + 1);
  localparam int unsigned SUM_W  = 16 + $clog2(MAX_NEIGHBOURS);
  localparam int unsigned PROD_W = SUM_W + 18;
  localparam int unsigned ACC_W  = PROD_W + 1;

  typedef enum logic [15:0] {
    ST_IDLE  = 16'h0001,
    ST_SQX   = 16'h0002,
    ST_SQZ   = 16'h0004,
    ST_THR   = 16'h0008,
    ST_DGO   = 16'h0010,
    ST_DWAIT = 16'h0020,
    ST_M2X   = 16'h0040,
    ST_M2Z   = 16'h0080,
    ST_C2    = 16'h0100,
    ST_SX0   = 16'h0200,
    ST_SX1   = 16'h0400,
    ST_SX2   = 16'h0800,
    ST_SZ0   = 16'h1000,
    ST_SZ1   = 16'h2000,
    ST_SZ2   = 16'h4000,
    ST_OUT   = 16'h8000
  } state_e;

  state_e state_q, state_d;

  rec_t                     rec_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [SUM_W-1:0]  pos_x_q, pos_z_q, vel_x_q, vel_z_q, disp_x_q, disp_z_q;
  logic signed [15:0]       mean_q [4];
  logic [1:0]               sel_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     coh_q;
  logic signed [15:0]       steer_x_q;
  logic                     out_valid_q;
  logic [15:0]              out_x_q, out_z_q;
  logic [3:0]               out_cnt_q;

  logic signed [SUM_W:0]    mul_a;
  logic signed [16:0]       mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc_sum;
  logic                     out_go;

  logic signed [SUM_W-1:0]  dvd_sel;
  logic                     dvd_neg;
  logic [SUM_W-1:0]         dvd_mag, quo, quo_s;
  logic                     div_done;
  logic [CNT_W+3:0]         cnt_ext;

  // round half up by 16 bits, then saturate to 16 bits
  function automatic logic [15:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0]  r;
    logic [ACC_W-16:0]        hi;
    r  = (v + ACC_W'(32768)) >>> 16;
    hi = r[ACC_W-1:15];
    if ((&hi) || !(|hi)) begin
      return r[15:0];
    end else begin
      return r[ACC_W-1] ? 16'h8000 : 16'h7fff;
    end
  endfunction

  assign q_pop_o = (state_q == ST_IDLE) & q_valid_i;
  assign out_go  = (state_q == ST_OUT) & (~out_valid_q | m_ready_i);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQX: begin
        mul_a = (SUM_W + 1)'(rec_q.rel_x);
        mul_b = 17'(rec_q.rel_x);
      end
      ST_SQZ: begin
        mul_a = (SUM_W + 1)'(rec_q.rel_z);
        mul_b = 17'(rec_q.rel_z);
      end
      ST_THR: begin
        mul_a = (SUM_W + 1)'({1'b0, cfg_i.disp_thr});
        mul_b = 17'({1'b0, cfg_i.disp_thr});
      end
      ST_M2X: begin
        mul_a = (SUM_W + 1)'(mean_q[0]);
        mul_b = 17'(mean_q[0]);
      end
      ST_M2Z: begin
        mul_a = (SUM_W + 1)'(mean_q[1]);
        mul_b = 17'(mean_q[1]);
      end
      ST_C2: begin
        mul_a = (SUM_W + 1)'({1'b0, cfg_i.coh_thr});
        mul_b = 17'({1'b0, cfg_i.coh_thr});
      end
      ST_SX0: begin
        mul_a = coh_q ? (SUM_W + 1)'(mean_q[0]) : '0;
        mul_b = 17'({1'b0, cfg_i.coh_w});
      end
      ST_SX1: begin
        mul_a = -((SUM_W + 1)'(disp_x_q));
        mul_b = 17'({1'b0, cfg_i.disp_w});
      end
      ST_SX2: begin
        mul_a = (SUM_W + 1)'(mean_q[2]);
        mul_b = 17'({1'b0, cfg_i.ali_w});
      end
      ST_SZ0: begin
        mul_a = coh_q ? (SUM_W + 1)'(mean_q[1]) : '0;
        mul_b = 17'({1'b0, cfg_i.coh_w});
      end
      ST_SZ1: begin
        mul_a = -((SUM_W + 1)'(disp_z_q));
        mul_b = 17'({1'b0, cfg_i.disp_w});
      end
      ST_SZ2: begin
        mul_a = (SUM_W + 1)'(mean_q[3]);
        mul_b = 17'({1'b0, cfg_i.ali_w});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign acc_sum = acc_q + ACC_W'(prod);

  // divider operand: magnitude of the selected sum
  always_comb begin
    case (sel_q)
      2'd0:    dvd_sel = pos_x_q;
      2'd1:    dvd_sel = pos_z_q;
      2'd2:    dvd_sel = vel_x_q;
      default: dvd_sel = vel_z_q;
    endcase
    dvd_neg = dvd_sel[SUM_W-1];
    dvd_mag = dvd_neg ? SUM_W'(-dvd_sel) : SUM_W'(dvd_sel);
    quo_s   = dvd_neg ? (~quo + SUM_W'(1)) : quo;
  end

  fsv_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == ST_DGO),
    .dividend_i (dvd_mag),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_rec_i.use_mate) state_d = ST_SQX;
          else if (cnt_q == '0) state_d = ST_OUT;
          else                  state_d = ST_DGO;
        end
      end
      ST_SQX:   state_d = ST_SQZ;
      ST_SQZ:   state_d = ST_THR;
      ST_THR:   state_d = rec_q.last ? ST_DGO : ST_IDLE;
      ST_DGO:   state_d = ST_DWAIT;
      ST_DWAIT: begin
        if (div_done) state_d = (sel_q == 2'd3) ? ST_M2X : ST_DGO;
      end
      ST_M2X:   state_d = ST_M2Z;
      ST_M2Z:   state_d = ST_C2;
      ST_C2:    state_d = ST_SX0;
      ST_SX0:   state_d = ST_SX1;
      ST_SX1:   state_d = ST_SX2;
      ST_SX2:   state_d = ST_SZ0;
      ST_SZ0:   state_d = ST_SZ1;
      ST_SZ1:   state_d = ST_SZ2;
      ST_SZ2:   state_d = ST_OUT;
      ST_OUT: begin
        if (out_go) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // control state and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      sel_q       <= '0;
      pos_x_q     <= '0;
      pos_z_q     <= '0;
      vel_x_q     <= '0;
      vel_z_q     <= '0;
      disp_x_q    <= '0;
      disp_z_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_go) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_THR: begin
          pos_x_q <= pos_x_q + SUM_W'(rec_q.rel_x);
          pos_z_q <= pos_z_q + SUM_W'(rec_q.rel_z);
          vel_x_q <= vel_x_q + SUM_W'(rec_q.vel_x);
          vel_z_q <= vel_z_q + SUM_W'(rec_q.vel_z);
          if (acc_q < ACC_W'(prod)) begin
            disp_x_q <= disp_x_q + SUM_W'(rec_q.rel_x);
            disp_z_q <= disp_z_q + SUM_W'(rec_q.rel_z);
          end
          cnt_q <= cnt_q + CNT_W'(1);
        end
        ST_DWAIT: begin
          if (div_done) sel_q <= sel_q + 2'd1;
        end
        ST_OUT: begin
          if (out_go) begin
            cnt_q    <= '0;
            sel_q    <= '0;
            pos_x_q  <= '0;
            pos_z_q  <= '0;
            vel_x_q  <= '0;
            vel_z_q  <= '0;
            disp_x_q <= '0;
            disp_z_q <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign cnt_ext = {4'b0, cnt_q};

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (q_pop_o) rec_q <= q_rec_i;
      end
      ST_SQX, ST_M2X, ST_SX0: acc_q <= ACC_W'(prod);
      ST_SQZ, ST_M2Z, ST_SX1, ST_SX2, ST_SZ1, ST_SZ2: acc_q <= acc_sum;
      ST_DWAIT: begin
        if (div_done) mean_q[sel_q] <= quo_s[15:0];
      end
      ST_C2: coh_q <= (acc_q > ACC_W'(prod));
      ST_SZ0: begin
        acc_q     <= ACC_W'(prod);
        steer_x_q <= round_sat(acc_q);
      end
      ST_OUT: begin
        if (out_go) begin
          out_x_q   <= (cnt_q == '0) ? 16'h0000 : steer_x_q;
          out_z_q   <= (cnt_q == '0) ? 16'h0000 : round_sat(acc_q);
          out_cnt_q <= cnt_ext[3:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = {out_z_q, out_x_q};
  assign m_user_o  = out_cnt_q;

endmodule

@@ rtl/core/fsv_checker.sv @@
// ----------------------------------------------------------------------------
// fsv_checker
// Port-level checks of the flocking steering vector block.
// ----------------------------------------------------------------------------
module fsv_checker import fsv_pkg::*; #(
  parameter int unsigned MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,   // steer_x, steer_z
  input logic [3:0]  m_axis_tuser    // mate_count
);

  // count limit only visible while it fits the 4-bit field
  localparam bit CNT_VISIBLE = (MAX_NEIGHBOURS < 16);

  // reset empties the output register
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // mate count never passes the neighbour limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && CNT_VISIBLE |-> (32'(m_axis_tuser) <= MAX_NEIGHBOURS))
    else $error("mate count above limit");

  // a step without mates steers nowhere
  a_zero_mates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && CNT_VISIBLE && (m_axis_tuser == 4'd0) |-> (m_axis_tdata == 32'd0))
    else $error("nonzero steering without mates");

endmodule

bind flocking_steer_vector fsv_checker #(
  .MAX_NEIGHBOURS(MAX_NEIGHBOURS)
) u_fsv_checker (.*);
